FILE: hdl/bt_pkg.sv
// Shared types, constants and the glyph font table for the text run rasterizer.
`default_nettype none

package bt_pkg;

    localparam int GLYPH_ROWS    = 7;
    localparam int GLYPH_COLS    = 5;
    localparam int CLIP_BITS     = 13;
    localparam int CURSOR_BITS   = 24;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 14;

    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_START_X     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_START_Y     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PIXEL_SCALE = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_HEIGHT = 3'd4;

    typedef logic [GLYPH_COLS-1:0] row_t;
    typedef row_t [GLYPH_ROWS-1:0] glyph_t;

    typedef struct packed {
        logic signed [13:0] start_x;
        logic signed [13:0] start_y;
        logic [5:0]         pixel_scale;
        logic [12:0]        clip_width;
        logic [12:0]        clip_height;
    } cfg_t;

    // one character handed from the front end to the rasterizing back end
    typedef struct packed {
        glyph_t                         glyph;
        logic signed [CURSOR_BITS-1:0]  cursor;
    } job_t;

    typedef struct packed {
        logic [CLIP_BITS-1:0] left;
        logic [CLIP_BITS-1:0] top;
        logic [CLIP_BITS-1:0] right;
        logic [CLIP_BITS-1:0] bottom;
        logic                 last;
    } rect_t;

    function automatic glyph_t mk_glyph(input row_t r0, input row_t r1, input row_t r2,
                                        input row_t r3, input row_t r4, input row_t r5,
                                        input row_t r6);
        glyph_t g;
        g[0] = r0;
        g[1] = r1;
        g[2] = r2;
        g[3] = r3;
        g[4] = r4;
        g[5] = r5;
        g[6] = r6;
        return g;
    endfunction

    // bit 4 of a row is the leftmost dot
    function automatic glyph_t glyph_lookup(input logic [7:0] code);
        glyph_t g;
        unique case (code)
            8'h30:   g = mk_glyph(5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E);
            8'h31:   g = mk_glyph(5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E);
            8'h32:   g = mk_glyph(5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F);
            8'h33:   g = mk_glyph(5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E);
            8'h3A:   g = mk_glyph(5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00);
            8'h41:   g = mk_glyph(5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11);
            8'h43:   g = mk_glyph(5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E);
            8'h44:   g = mk_glyph(5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E);
            8'h45:   g = mk_glyph(5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F);
            8'h46:   g = mk_glyph(5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10);
            8'h47:   g = mk_glyph(5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E);
            8'h48:   g = mk_glyph(5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11);
            8'h49:   g = mk_glyph(5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F);
            8'h4C:   g = mk_glyph(5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F);
            8'h4E:   g = mk_glyph(5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11);
            8'h4F:   g = mk_glyph(5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E);
            8'h50:   g = mk_glyph(5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10);
            8'h52:   g = mk_glyph(5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11);
            8'h53:   g = mk_glyph(5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E);
            8'h54:   g = mk_glyph(5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04);
            8'h55:   g = mk_glyph(5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E);
            8'h56:   g = mk_glyph(5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04);
            // fallback question mark
            default: g = mk_glyph(5'h0E, 5'h11, 5'h01, 5'h06, 5'h04, 5'h00, 5'h04);
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/bitmap_text_run_rasterizer.sv
// Top level of the 5x7 bitmap text run rasterizer.
//
// Usage: write one character code per transaction on the input queue
// (push/full). Each character is drawn as filled rectangles, one per
// horizontal run of set dots in its 5x7 glyph, scaled by pixel_scale,
// placed at the pen cursor and the line origin, and clipped to the window
// [0,clip_width) x [0,clip_height). Rectangles come out of the result queue
// (empty/pop) in row order, left to right; last_rect marks the final one of
// a character. Characters with no visible run, and spaces, give none.
// A character's rectangles pass through the job queue, the scanner's token
// register, the held-back rectangle register and the result queue, and are
// delayed further while the back end is still busy with an earlier character.
// The rasterizer loads the character, scans one dot run or one empty glyph
// row per step, and closes the character; a space only moves the cursor
// in the front end and never reaches the back end.
// A two-entry job queue lets the front end take the next character while
// the back end is busy; a stalled result queue holds the back end, and full
// rises once the job queue fills. Configuration writes (cfg_valid/cfg_ready,
// always ready) are to be made while the block is idle. Reset empties both
// queues, restores the register defaults and puts the cursor at 0.
`default_nettype none

module bitmap_text_run_rasterizer
    import bt_pkg::*;
#(
    parameter int COORD_BITS = 13
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // character input queue
    input  wire logic                     push,
    output logic                          full,
    input  wire logic [7:0]               char_code,
    input  wire logic                     line_start,
    // rectangle result queue
    output logic                          empty,
    input  wire logic                     pop,
    output logic [COORD_BITS-1:0]         rect_left,
    output logic [COORD_BITS-1:0]         rect_top,
    output logic [COORD_BITS-1:0]         rect_right,
    output logic [COORD_BITS-1:0]         rect_bottom,
    output logic                          last_rect,
    // configuration write channel
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

    cfg_t  cfg_reg, cfg_next;
    job_t  front_job, back_job;
    logic  job_push, job_full, job_empty, job_pop;
    logic  res_push, res_full;
    rect_t back_res, out_res;
    logic [$bits(job_t)-1:0]  job_rd_data;
    logic [$bits(rect_t)-1:0] res_rd_data;

    // Register file: always ready, writes to unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_START_X:     cfg_next.start_x     = cfg_data;
                CFG_START_Y:     cfg_next.start_y     = cfg_data;
                CFG_PIXEL_SCALE: cfg_next.pixel_scale = cfg_data[5:0];
                CFG_CLIP_WIDTH:  cfg_next.clip_width  = cfg_data[12:0];
                CFG_CLIP_HEIGHT: cfg_next.clip_height = cfg_data[12:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_x     <= '0;
            cfg_reg.start_y     <= '0;
            cfg_reg.pixel_scale <= 6'd1;
            cfg_reg.clip_width  <= 13'd640;
            cfg_reg.clip_height <= 13'd480;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: cursor bookkeeping and glyph lookup.
    bt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .push       (push),
        .full       (full),
        .char_code  (char_code),
        .line_start (line_start),
        .job_push   (job_push),
        .job        (front_job),
        .job_full   (job_full)
    );

    // Job queue: decouples lookup from rasterizing.
    bt_fifo #(
        .WIDTH ($bits(job_t)),
        .DEPTH (2)
    ) u_job_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (front_job),
        .full    (job_full),
        .rd_en   (job_pop),
        .rd_data (job_rd_data),
        .empty   (job_empty)
    );

    assign back_job = job_t'(job_rd_data);

    // Back end: run scanning, scaling, clipping and last marking.
    bt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job       (back_job),
        .job_empty (job_empty),
        .job_pop   (job_pop),
        .res_push  (res_push),
        .res       (back_res),
        .res_full  (res_full)
    );

    // Result queue: holds finished rectangles while the receiver stalls.
    bt_fifo #(
        .WIDTH ($bits(rect_t)),
        .DEPTH (2)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (back_res),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_rd_data),
        .empty   (empty)
    );

    // Coordinates leave at COORD_BITS: truncate or zero-extend.
    assign out_res     = rect_t'(res_rd_data);
    assign rect_left   = COORD_BITS'(out_res.left);
    assign rect_top    = COORD_BITS'(out_res.top);
    assign rect_right  = COORD_BITS'(out_res.right);
    assign rect_bottom = COORD_BITS'(out_res.bottom);
    assign last_rect   = out_res.last;

endmodule

`default_nettype wire

FILE: hdl/bt_fifo.sv
// Small register-based first-in first-out queue.
`default_nettype none

module bt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  empty
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

    logic [WIDTH-1:0]    mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_wr, do_rd;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/bt_front.sv
// Front end: accepts characters, keeps the pen cursor and looks up glyphs.
`default_nettype none

module bt_front
    import bt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_t       cfg,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] char_code,
    input  wire logic       line_start,
    output logic            job_push,
    output job_t            job,
    input  wire logic       job_full
);

    logic signed [CURSOR_BITS-1:0] cursor_reg, cursor_next;
    logic signed [CURSOR_BITS-1:0] cur;
    logic                          accept;
    logic                          is_space;
    logic [8:0]                    advance;
    logic [CURSOR_BITS:0]          sum;

    assign full     = job_full;
    assign accept   = push && !job_full;
    assign is_space = (char_code == CHAR_SPACE);

    always_comb
    begin
        cur = line_start
            ? CURSOR_BITS'(cfg.start_x)
            : cursor_reg;
        // space advances 4 dots, everything else 6
        advance = is_space
            ? {1'b0, cfg.pixel_scale, 2'b00}
            : ({1'b0, cfg.pixel_scale, 2'b00} + {2'b00, cfg.pixel_scale, 1'b0});
        sum = {cur[CURSOR_BITS-1], cur} + {{(CURSOR_BITS-8){1'b0}}, advance};
        cursor_next = cursor_reg;
        if (accept)
        begin
            // only positive steps, so overflow can only hit the top
            if (sum[CURSOR_BITS] != sum[CURSOR_BITS-1])
            begin
                cursor_next = {1'b0, {(CURSOR_BITS-1){1'b1}}};
            end
            else
            begin
                cursor_next = sum[CURSOR_BITS-1:0];
            end
        end
    end

    assign job_push   = accept && !is_space;
    assign job.glyph  = glyph_lookup(char_code);
    assign job.cursor = cur;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
        end
        else
        begin
            cursor_reg <= cursor_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/bt_back.sv
// Back end: walks glyph rows, turns dot runs into clipped rectangles.
`default_nettype none

module bt_back
    import bt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire job_t job,
    input  wire logic job_empty,
    output logic      job_pop,
    output logic      res_push,
    output rect_t     res,
    input  wire logic res_full
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_END} phase_t;

    typedef struct packed {
        logic [2:0] first;
        logic [2:0] stop;
    } run_t;

    function automatic run_t find_run(input row_t m);
        run_t r;
        logic found;
        logic done;
        r.first = 3'd5;
        r.stop  = 3'd5;
        found   = 1'b0;
        done    = 1'b0;
        for (int c = 0; c < GLYPH_COLS; c++)
        begin
            if (!found && m[GLYPH_COLS-1-c])
            begin
                r.first = 3'(c);
                found   = 1'b1;
            end
            else if (found && !done && !m[GLYPH_COLS-1-c])
            begin
                r.stop = 3'(c);
                done   = 1'b1;
            end
        end
        return r;
    endfunction

    // scanner state
    phase_t                        phase_reg, phase_next;
    glyph_t                        rows_reg, rows_next;
    logic [2:0]                    row_reg, row_next;
    logic signed [CURSOR_BITS-1:0] cursor_reg, cursor_next;
    logic signed [14:0]            top_reg, top_next;

    // token between scanner and clipper
    logic                          tok_valid_reg, tok_valid_next;
    logic                          tok_end_reg, tok_end_next;
    logic signed [CURSOR_BITS:0]   tok_l_reg, tok_l_next;
    logic signed [CURSOR_BITS:0]   tok_r_reg, tok_r_next;
    logic signed [14:0]            tok_t_reg, tok_t_next;
    logic signed [14:0]            tok_b_reg, tok_b_next;

    // rectangle held back until we know whether it is the last one
    logic                          pend_valid_reg, pend_valid_next;
    rect_t                         pend_reg, pend_next;

    logic                          clip_ready;
    logic                          scan_adv;
    run_t                          run;
    row_t                          remain;
    logic [8:0]                    off_l, off_r;
    logic signed [14:0]            scale15;
    logic                          next_row;

    logic signed [CURSOR_BITS:0]   cw_x;
    logic signed [14:0]            ch_x;
    logic                          reject;
    logic                          visible;
    logic [CLIP_BITS-1:0]          l_c, t_c, r_c, b_c;

    assign clip_ready = !res_full;
    assign scan_adv   = !tok_valid_reg || clip_ready;
    assign scale15    = $signed({9'b0, cfg.pixel_scale});
    assign run        = find_run(rows_reg[0]);
    assign remain     = rows_reg[0] & (5'h1F >> run.stop);
    assign off_l      = 9'(run.first) * 9'(cfg.pixel_scale);
    assign off_r      = 9'(run.stop) * 9'(cfg.pixel_scale);

    // scanner
    always_comb
    begin
        phase_next     = phase_reg;
        rows_next      = rows_reg;
        row_next       = row_reg;
        cursor_next    = cursor_reg;
        top_next       = top_reg;
        tok_valid_next = tok_valid_reg;
        tok_end_next   = tok_end_reg;
        tok_l_next     = tok_l_reg;
        tok_r_next     = tok_r_reg;
        tok_t_next     = tok_t_reg;
        tok_b_next     = tok_b_reg;
        job_pop        = 1'b0;
        next_row       = 1'b0;
        if (scan_adv)
        begin
            tok_valid_next = 1'b0;
            unique case (phase_reg)
                S_IDLE:
                begin
                    if (!job_empty)
                    begin
                        job_pop     = 1'b1;
                        rows_next   = job.glyph;
                        cursor_next = job.cursor;
                        row_next    = '0;
                        top_next    = $signed({cfg.start_y[13], cfg.start_y});
                        phase_next  = S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (rows_reg[0] != '0)
                    begin
                        tok_valid_next = 1'b1;
                        tok_end_next   = 1'b0;
                        tok_l_next     = $signed({cursor_reg[CURSOR_BITS-1], cursor_reg})
                                       + $signed({{(CURSOR_BITS-8){1'b0}}, off_l});
                        tok_r_next     = $signed({cursor_reg[CURSOR_BITS-1], cursor_reg})
                                       + $signed({{(CURSOR_BITS-8){1'b0}}, off_r});
                        tok_t_next     = top_reg;
                        tok_b_next     = top_reg + scale15;
                        rows_next[0]   = remain;
                        next_row       = (remain == '0);
                    end
                    else
                    begin
                        next_row = 1'b1;
                    end
                    if (next_row)
                    begin
                        if (row_reg == 3'(GLYPH_ROWS - 1))
                        begin
                            phase_next = S_END;
                        end
                        else
                        begin
                            rows_next = rows_reg >> GLYPH_COLS;
                            row_next  = row_reg + 1'b1;
                            top_next  = top_reg + scale15;
                        end
                    end
                end
                S_END:
                begin
                    tok_valid_next = 1'b1;
                    tok_end_next   = 1'b1;
                    phase_next     = S_IDLE;
                end
                default:
                begin
                    phase_next = S_IDLE;
                end
            endcase
        end
    end

    // clipper
    always_comb
    begin
        cw_x   = $signed({12'b0, cfg.clip_width});
        ch_x   = $signed({2'b0, cfg.clip_height});
        reject = (tok_r_reg <= 25'sd0) || (tok_b_reg <= 15'sd0)
              || (tok_l_reg >= cw_x) || (tok_t_reg >= ch_x);
        l_c    = tok_l_reg[CURSOR_BITS] ? '0 : tok_l_reg[CLIP_BITS-1:0];
        t_c    = tok_t_reg[14] ? '0 : tok_t_reg[CLIP_BITS-1:0];
        r_c    = (tok_r_reg > cw_x) ? cfg.clip_width : tok_r_reg[CLIP_BITS-1:0];
        b_c    = (tok_b_reg > ch_x) ? cfg.clip_height : tok_b_reg[CLIP_BITS-1:0];
        visible = !reject && (l_c < r_c) && (t_c < b_c);

        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        res_push        = 1'b0;
        res             = pend_reg;
        res.last        = 1'b0;
        if (tok_valid_reg && clip_ready)
        begin
            if (tok_end_reg)
            begin
                // flush the held rectangle as the final one
                res_push        = pend_valid_reg;
                res.last        = 1'b1;
                pend_valid_next = 1'b0;
            end
            else if (visible)
            begin
                res_push        = pend_valid_reg;
                pend_valid_next = 1'b1;
                pend_next.left   = l_c;
                pend_next.top    = t_c;
                pend_next.right  = r_c;
                pend_next.bottom = b_c;
                pend_next.last   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= S_IDLE;
            tok_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            tok_valid_reg  <= tok_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rows_reg    <= rows_next;
        row_reg     <= row_next;
        cursor_reg  <= cursor_next;
        top_reg     <= top_next;
        tok_end_reg <= tok_end_next;
        tok_l_reg   <= tok_l_next;
        tok_r_reg   <= tok_r_next;
        tok_t_reg   <= tok_t_next;
        tok_b_reg   <= tok_b_next;
        pend_reg    <= pend_next;
    end

endmodule

`default_nettype wire

FILE: dv/tb.sv
// Self-checking testbench for the 5x7 bitmap text run rasterizer.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bt_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    // two queued jobs plus one in the back end
    localparam int LATENCY_PAD  = 80;
    localparam longint PEN_MAX  = 64'sd8388607;
    localparam longint PEN_MIN  = -64'sd8388608;
    localparam int MAX_RUNS     = 21;
    localparam logic [8*22-1:0] FONT_CODES = "0123:ACDEFGHILNOPRSTUV";

    logic                     clk;
    logic                     rst_n;
    logic                     push;
    logic                     full;
    logic [7:0]               char_code;
    logic                     line_start;
    logic                     empty;
    logic                     pop;
    logic [12:0]              rect_left;
    logic [12:0]              rect_top;
    logic [12:0]              rect_right;
    logic [12:0]              rect_bottom;
    logic                     last_rect;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    // shadow copy of the register file and the pen position
    logic signed [13:0] win_start_x;
    logic signed [13:0] win_start_y;
    logic [5:0]         win_scale;
    logic [12:0]        win_width;
    logic [12:0]        win_height;
    longint             pen_x;

    // rectangles still owed by the block, oldest first
    rect_t              pending_rects[$];

    int                 mismatches = 0;
    int                 cycles = 0;
    // set while neither side is allowed to idle
    bit                 calm = 1'b0;

    bitmap_text_run_rasterizer #(
        .COORD_BITS(13)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .char_code  (char_code),
        .line_start (line_start),
        .empty      (empty),
        .pop        (pop),
        .rect_left  (rect_left),
        .rect_top   (rect_top),
        .rect_right (rect_right),
        .rect_bottom(rect_bottom),
        .last_rect  (last_rect),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Font rows packed row 0 first; bit 4 of each row is the leftmost dot.
    function automatic logic [34:0] glyph_dots(input logic [7:0] code);
        case (code)
            "0":     return {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
            "1":     return {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            "2":     return {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
            "3":     return {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
            ":":     return {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00};
            "A":     return {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            "C":     return {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
            "D":     return {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
            "E":     return {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
            "F":     return {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
            "G":     return {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E};
            "H":     return {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            "I":     return {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F};
            "L":     return {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
            "N":     return {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
            "O":     return {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            "P":     return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
            "R":     return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
            "S":     return {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
            "T":     return {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            "U":     return {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            "V":     return {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
            // anything else draws a question mark
            default: return {5'h0E, 5'h11, 5'h01, 5'h06, 5'h04, 5'h00, 5'h04};
        endcase
    endfunction

    // Move the pen, pinning it at the ends of its 24-bit range.
    function automatic void advance_pen(input longint step);
        pen_x = pen_x + step;
        if (pen_x > PEN_MAX)
            pen_x = PEN_MAX;
        if (pen_x < PEN_MIN)
            pen_x = PEN_MIN;
    endfunction

    // Work out the rectangles of one accepted character and queue them.
    function automatic void raster_char(input logic [7:0] code, input logic restart);
        logic [34:0] dots;
        logic [4:0]  bits;
        longint      l, t, r, b, sc, cw, ch;
        int          row, col, first, runs;
        rect_t       held;
        bit          have;

        if (restart)
            pen_x = longint'(win_start_x);
        sc = longint'(win_scale);
        cw = longint'(win_width);
        ch = longint'(win_height);
        if (code == CHAR_SPACE)
        begin
            advance_pen(4 * sc);
            return;
        end
        dots = glyph_dots(code);
        have = 1'b0;
        runs = 0;
        for (row = 0; row < GLYPH_ROWS; row++)
        begin
            bits = dots[34 - 5 * row -: 5];
            col = 0;
            while (col < GLYPH_COLS)
            begin
                while (col < GLYPH_COLS && !bits[4 - col])
                    col++;
                first = col;
                while (col < GLYPH_COLS && bits[4 - col])
                    col++;
                if (first != col)
                begin
                    l = pen_x + first * sc;
                    t = longint'(win_start_y) + row * sc;
                    r = pen_x + col * sc;
                    b = t + sc;
                    // drop runs that miss the window entirely
                    if (!(r <= 0 || b <= 0 || l >= cw || t >= ch))
                    begin
                        if (l < 0)  l = 0;
                        if (t < 0)  t = 0;
                        if (r > cw) r = cw;
                        if (b > ch) b = ch;
                        if (l < r && t < b && runs < MAX_RUNS)
                        begin
                            // hold each rectangle back one step so the final one
                            // can be flagged
                            if (have)
                                pending_rects.push_back(held);
                            held.left   = l[12:0];
                            held.top    = t[12:0];
                            held.right  = r[12:0];
                            held.bottom = b[12:0];
                            held.last   = 1'b0;
                            have = 1'b1;
                            runs++;
                        end
                    end
                end
            end
        end
        if (have)
        begin
            held.last = 1'b1;
            pending_rects.push_back(held);
        end
        advance_pen(6 * sc);
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Take results, stall pop at random, and compare each rectangle with the
    // oldest one owed.
    always @(posedge clk)
    begin : result_check
        rect_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_rects.size() == 0)
                report_mismatch($sformatf("unexpected rect %0d,%0d,%0d,%0d last=%0d",
                                          rect_left, rect_top, rect_right, rect_bottom,
                                          last_rect));
            else
            begin
                want = pending_rects.pop_front();
                if (rect_left !== want.left)
                    report_mismatch($sformatf("rect_left %0d, expected %0d",
                                              rect_left, want.left));
                if (rect_top !== want.top)
                    report_mismatch($sformatf("rect_top %0d, expected %0d",
                                              rect_top, want.top));
                if (rect_right !== want.right)
                    report_mismatch($sformatf("rect_right %0d, expected %0d",
                                              rect_right, want.right));
                if (rect_bottom !== want.bottom)
                    report_mismatch($sformatf("rect_bottom %0d, expected %0d",
                                              rect_bottom, want.bottom));
                if (last_rect !== want.last)
                    report_mismatch($sformatf("last_rect %0d, expected %0d",
                                              last_rect, want.last));
            end
        end
        pop <= calm || ($urandom_range(0, 99) >= 6);
    end

    // Write one register and mirror it; the block is idle whenever this runs.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_START_X:     win_start_x = value;
            CFG_START_Y:     win_start_y = value;
            CFG_PIXEL_SCALE: win_scale   = value[5:0];
            CFG_CLIP_WIDTH:  win_width   = value[12:0];
            CFG_CLIP_HEIGHT: win_height  = value[12:0];
            default:         ;
        endcase
        // drop valid before the next transaction
        @(posedge clk);
    endtask

    // Program the whole window; unused high data bits carry noise.
    task automatic set_window(input int sx, input int sy, input int sc,
                              input int cw, input int ch);
        logic [7:0] noise;
        noise = 8'($urandom);
        write_reg(CFG_START_X, sx[13:0]);
        write_reg(CFG_START_Y, sy[13:0]);
        write_reg(CFG_PIXEL_SCALE, {noise, sc[5:0]});
        write_reg(CFG_CLIP_WIDTH, {noise[0], cw[12:0]});
        write_reg(CFG_CLIP_HEIGHT, {noise[1], ch[12:0]});
    endtask

    // Offer one character and predict its rectangles once it is taken.
    // Push stays high afterwards so back-to-back characters need no gap.
    task automatic send_char(input logic [7:0] code, input logic restart);
        if (!calm && $urandom_range(0, 99) < 6)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        push       <= 1'b1;
        char_code  <= code;
        line_start <= restart;
        do
            @(posedge clk);
        while (full);
        raster_char(code, restart);
    endtask

    // Drop push, wait for every owed rectangle, then optionally let any
    // invisible characters still in flight drain out.
    task automatic drain(input bit settle);
        push <= 1'b0;
        @(posedge clk);
        while (pending_rects.size() != 0)
            @(posedge clk);
        if (settle)
            repeat (LATENCY_PAD) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_char();
        int sel;
        int k;
        sel = $urandom_range(0, 99);
        k   = $urandom_range(0, 21);
        if (sel < 75)
            return FONT_CODES[8 * k +: 8];
        else if (sel < 85)
            return CHAR_SPACE;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // Reset defaults: every font class, a space and codes outside the font.
    task automatic test_font_and_fallback();
        send_char("0", 1'b1);
        send_char("A", 1'b0);
        send_char(":", 1'b0);
        send_char("I", 1'b0);
        send_char(CHAR_SPACE, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        drain(1'b1);
    endtask

    // Partial clipping on the left and bottom, rows dropped above the top, then a glyph past the right edge.
    task automatic test_clip_edges();
        set_window(-3, -2, 2, 20, 9);
        send_char("H", 1'b1);
        send_char("N", 1'b0);
        send_char("O", 1'b0);
        drain(1'b1);
    endtask

    // Zero scale draws nothing and freezes the pen; a zero window rejects all.
    task automatic test_zero_scale_and_window();
        set_window(5, 5, 0, 640, 480);
        send_char("E", 1'b1);
        send_char(CHAR_SPACE, 1'b0);
        drain(1'b1);
        write_reg(CFG_PIXEL_SCALE, 14'd1);
        send_char("E", 1'b0);
        drain(1'b1);
        write_reg(CFG_CLIP_WIDTH, 14'd0);
        send_char("A", 1'b1);
        drain(1'b1);
        write_reg(CFG_CLIP_WIDTH, 14'd640);
        write_reg(CFG_CLIP_HEIGHT, 14'd0);
        send_char("A", 1'b1);
        drain(1'b1);
    endtask

    // Register extremes; a start_x write alone must leave the pen in place.
    task automatic test_register_extremes();
        set_window(8191, -8192, 63, 8191, 8191);
        send_char("A", 1'b1);
        drain(1'b1);
        write_reg(CFG_START_X, 14'd7800);
        write_reg(CFG_START_Y, 14'd7800);
        send_char("M", 1'b0);
        send_char("H", 1'b1);
        drain(1'b1);
        set_window(-8192, -100, 63, 1, 1);
        send_char("T", 1'b1);
        drain(1'b1);
    endtask

    // Step the pen far along the line with wide spaces, then restart the line.
    task automatic test_wide_spaces();
        int k;
        set_window(0, 0, 63, 640, 480);
        send_char(CHAR_SPACE, 1'b1);
        for (k = 0; k < 20; k++)
            send_char(CHAR_SPACE, 1'b0);
        send_char("A", 1'b0);
        send_char("A", 1'b1);
        drain(1'b1);
    endtask

    // Random windows and text lines; one phase runs with no idling at all and
    // one pauses mid-line until every owed rectangle has come out.
    task automatic test_random_text();
        int phase;
        int k;
        int mode;
        for (phase = 0; phase < 10; phase++)
        begin
            mode = $urandom_range(0, 9);
            if (mode < 3)
                set_window($urandom_range(0, 8100), $urandom_range(0, 8100),
                           $urandom_range(1, 63), 8191, 8191);
            else if (mode < 8)
                set_window(int'($urandom_range(0, 420)) - 20, int'($urandom_range(0, 420)) - 20,
                           $urandom_range(1, 4), $urandom_range(64, 1023),
                           $urandom_range(32, 1023));
            else
                set_window($urandom_range(0, 16383), $urandom_range(0, 16383),
                           ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 63),
                           ($urandom_range(0, 3) == 0) ? 8191 : $urandom_range(0, 8191),
                           ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(0, 8191));
            calm = (phase == 4);
            for (k = 0; k < 20; k++)
            begin
                if (phase == 2 && k == 12)
                    drain(1'b0);
                send_char(pick_char(), (k == 0) || ($urandom_range(0, 19) == 0));
            end
            drain(1'b1);
            calm = 1'b0;
        end
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        push       <= 1'b0;
        char_code  <= 8'h00;
        line_start <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= CFG_START_X;
        cfg_data   <= '0;
        // register defaults after reset
        win_start_x = 14'sd0;
        win_start_y = 14'sd0;
        win_scale   = 6'd1;
        win_width   = 13'd640;
        win_height  = 13'd480;
        pen_x       = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_font_and_fallback();
        test_clip_edges();
        test_zero_scale_and_window();
        test_register_extremes();
        test_wide_spaces();
        test_random_text();

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
